### sv/hm_pkg.sv
// hm_pkg: shared constants, types and state codes of the heightmap sampler
// no dependencies; every other file but hm_grid_mem uses it, by scoped names or by import
`timescale 1ns / 1ps
`default_nettype none

package hm_pkg;

	// default geometry
	localparam int GRID_VERTS_DEF = 65;
	localparam int FRAC_BITS_DEF  = 8;

	// item field widths
	localparam int POS_W    = 24;
	localparam int RECIP_W  = 24;
	localparam int HEIGHT_W = 16;

	// fraction bits of a world by reciprocal product (Q16.8 times Q8.16)
	localparam int PROD_FRAC = 24;

	// height range of a result
	localparam int HEIGHT_MAX = 32767;
	localparam int HEIGHT_MIN = -32768;

	// shared multiplier, sized for the largest fraction width (12 bits)
	localparam int MUL_A_W = 29;
	localparam int MUL_B_W = 25;
	localparam int ACC_W   = 49;

	// item actions
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// configuration port
	localparam int                 PADDR_W        = 3;
	localparam int                 PDATA_W        = 32;
	localparam int                 REG_IDX_W      = 1;
	localparam logic [REG_IDX_W-1:0] REG_CELL_RECIP = 1'b0;
	localparam logic [RECIP_W-1:0] RECIP_RESET    = 24'd65536;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_ADDR,
		ST_WR_MEM,
		ST_SCALE_X,
		ST_SCALE_Z,
		ST_FIX_Z,
		ST_ADDR,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_RD4,
		ST_BL0,
		ST_BL1,
		ST_DONE
	} seq_state_t;

	// one step for the shared multiply-accumulate unit
	typedef struct packed {
		logic                      en;
		logic                      load;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
		logic signed [ACC_W-1:0]   addend;
	} mac_op_t;

endpackage

`default_nettype wire

### sv/hm_if.sv
// hm_item_if and hm_result_if: valid/ready channels of the heightmap sampler
// depends on hm_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface hm_item_if;
	logic                               valid;
	logic                               ready;
	logic                               action;
	logic [hm_pkg::POS_W-1:0]           pos_x;
	logic [hm_pkg::POS_W-1:0]           pos_z;
	logic signed [hm_pkg::HEIGHT_W-1:0] height_in;

	modport source (output valid, action, pos_x, pos_z, height_in, input ready);
	modport sink   (input valid, action, pos_x, pos_z, height_in, output ready);
endinterface

interface hm_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [hm_pkg::HEIGHT_W-1:0] height_out;

	modport source (output valid, height_out, input ready);
	modport sink   (input valid, height_out, output ready);
endinterface

`default_nettype wire

### sv/heightmap_bilinear_sampler.sv
// heightmap_bilinear_sampler: top level with the register port
// depends on hm_pkg, hm_if, hm_grid_mem, hm_mac, hm_seq
`timescale 1ns / 1ps
`default_nettype none

// Keeps a GRID_VERTS x GRID_VERTS grid of signed 16-bit heights in one
// single-port memory. A write item stores a height at (pos_x, pos_z) in the grid and
// gives no result; a sample item scales world Q16.8 coordinates by
// cell_reciprocal and returns the bilinear blend of the four neighbors.
// After reset a clearing pass zeroes all GRID_VERTS*GRID_VERTS entries (4225
// at the default size), one entry a cycle; item_in.ready stays low during it
// while register writes are taken. One item is worked at a time, through the
// single multiply-accumulate unit and the one memory port, which fetches the
// four neighbors of a sample in turn. A result waits in an output register,
// so the next item may be accepted before it is taken.
// cell_reciprocal sits at byte address 0 of the APB port.
module heightmap_bilinear_sampler #(
	parameter int GRID_VERTS = hm_pkg::GRID_VERTS_DEF,
	parameter int FRAC_BITS  = hm_pkg::FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [hm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [hm_pkg::PDATA_W-1:0]  pwdata,
	output logic      [hm_pkg::PDATA_W-1:0]  prdata,
	output logic                             pready,
	hm_item_if.sink                          item_in,
	hm_result_if.source                      result_out
);

	localparam int CELLS  = GRID_VERTS * GRID_VERTS;
	localparam int ADDR_W = $clog2(CELLS);

	logic [hm_pkg::RECIP_W-1:0]      recip_q;
	logic [hm_pkg::REG_IDX_W-1:0]    reg_idx;
	logic                            mem_we;
	logic [ADDR_W-1:0]               mem_addr;
	logic [hm_pkg::HEIGHT_W-1:0]     mem_wdata, mem_rdata;
	hm_pkg::mac_op_t                 mac_op;
	logic signed [hm_pkg::ACC_W-1:0] acc;

	// register port decode
	assign reg_idx = paddr[hm_pkg::PADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_q <= hm_pkg::RECIP_RESET;
		end else if (psel && penable && pwrite && reg_idx == hm_pkg::REG_CELL_RECIP) begin
			recip_q <= pwdata[hm_pkg::RECIP_W-1:0];
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			hm_pkg::REG_CELL_RECIP: prdata = {{(hm_pkg::PDATA_W-hm_pkg::RECIP_W){1'b0}}, recip_q};
			default:                prdata = '0;
		endcase
	end

	hm_grid_mem #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W),
		.DATA_W (hm_pkg::HEIGHT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	hm_mac u_mac (
		.clk (clk),
		.op  (mac_op),
		.acc (acc)
	);

	hm_seq #(
		.GRID_VERTS (GRID_VERTS),
		.FRAC_BITS  (FRAC_BITS),
		.ADDR_W     (ADDR_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.recip      (recip_q),
		.item_in    (item_in),
		.result_out (result_out),
		.mem_we     (mem_we),
		.mem_addr   (mem_addr),
		.mem_wdata  (mem_wdata),
		.mem_rdata  (mem_rdata),
		.mac_op     (mac_op),
		.acc        (acc)
	);

endmodule

`default_nettype wire

### sv/hm_grid_mem.sv
// hm_grid_mem: single-port height grid, one access per cycle, registered read
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module hm_grid_mem #(
	parameter int DEPTH  = 4225,
	parameter int ADDR_W = 13,
	parameter int DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write when we is set, and read at the same address every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### sv/hm_mac.sv
// hm_mac: shared signed multiply-accumulate unit of the sampler
// depends on hm_pkg for operand widths and the mac_op_t step
`timescale 1ns / 1ps
`default_nettype none

module hm_mac (
	input  wire logic                          clk,
	input  wire hm_pkg::mac_op_t               op,
	output logic signed [hm_pkg::ACC_W-1:0]    acc
);

	logic signed [hm_pkg::MUL_A_W+hm_pkg::MUL_B_W-1:0] prod;
	logic signed [hm_pkg::ACC_W-1:0]                   acc_q;

	assign prod = op.a * op.b;

	// load starts from the addend, otherwise the product adds on
	always_ff @(posedge clk) begin
		if (op.en) begin
			acc_q <= (op.load ? op.addend : acc_q) + prod[hm_pkg::ACC_W-1:0];
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

### sv/hm_seq.sv
// hm_seq: sequencer of the sampler; drives the shared mac and the grid memory
// depends on hm_pkg, hm_if; owns the result output register
`timescale 1ns / 1ps
`default_nettype none

module hm_seq #(
	parameter int GRID_VERTS = hm_pkg::GRID_VERTS_DEF,
	parameter int FRAC_BITS  = hm_pkg::FRAC_BITS_DEF,
	parameter int ADDR_W     = $clog2(GRID_VERTS * GRID_VERTS)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [hm_pkg::RECIP_W-1:0]        recip,
	hm_item_if.sink                                item_in,
	hm_result_if.source                            result_out,
	output logic                                   mem_we,
	output logic      [ADDR_W-1:0]                 mem_addr,
	output logic      [hm_pkg::HEIGHT_W-1:0]       mem_wdata,
	input  wire logic [hm_pkg::HEIGHT_W-1:0]       mem_rdata,
	output hm_pkg::mac_op_t                        mac_op,
	input  wire logic signed [hm_pkg::ACC_W-1:0]   acc
);

	localparam int CELLS = GRID_VERTS * GRID_VERTS;
	localparam int IW    = $clog2(GRID_VERTS);
	localparam int WW    = FRAC_BITS + 1;
	localparam int SHIFT = 2 * FRAC_BITS;
	localparam logic [WW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam int PW    = hm_pkg::POS_W;
	localparam int AW_M  = hm_pkg::MUL_A_W;
	localparam int BW_M  = hm_pkg::MUL_B_W;
	localparam int CW    = hm_pkg::ACC_W;

	hm_pkg::seq_state_t state_q, state_d;

	logic [ADDR_W-1:0]                   clr_q;
	logic [PW-1:0]                       px_q, pz_q;
	logic [hm_pkg::HEIGHT_W-1:0]         hin_q;
	logic [IW-1:0]                       xi_q, zi_q;
	logic [WW-1:0]                       fx_q, fz_q;
	logic                                x_ok_q, z_ok_q;
	logic [ADDR_W-1:0]                   base_q;
	logic signed [AW_M-1:0]              row_a_q;
	logic                                out_valid_q;
	logic signed [hm_pkg::HEIGHT_W-1:0]  height_q;
	logic                                load_out;

	// grid coordinate of the product in acc: integer part, fraction, edge cases
	logic [PW-1:0]        ci_full;
	logic [FRAC_BITS-1:0] cf;
	logic                 c_in_grid, c_last;
	logic [IW-1:0]        ci_adj;
	logic [WW-1:0]        cf_adj;

	assign ci_full   = acc[hm_pkg::PROD_FRAC +: PW];
	assign cf        = acc[hm_pkg::PROD_FRAC-1 -: FRAC_BITS];
	assign c_in_grid = ci_full < PW'(GRID_VERTS);
	assign c_last    = ci_full == PW'(GRID_VERTS - 1);

	// last vertex steps back one cell with a full fraction
	always_comb begin
		if (!c_in_grid) begin
			ci_adj = '0;
		end else if (c_last) begin
			ci_adj = IW'(GRID_VERTS - 2);
		end else begin
			ci_adj = ci_full[IW-1:0];
		end
		cf_adj = c_last ? ONE : {1'b0, cf};
	end

	// mac operands: height read back (zero outside the grid) and weights
	logic signed [AW_M-1:0] h_eff;
	logic [WW-1:0]          om_fx, om_fz;
	logic [BW_M-1:0]        w_fx, w_fz, w_om_fx, w_om_fz;

	assign h_eff   = (x_ok_q && z_ok_q) ?
		{{(AW_M-hm_pkg::HEIGHT_W){mem_rdata[hm_pkg::HEIGHT_W-1]}}, mem_rdata} : '0;
	assign om_fx   = ONE - fx_q;
	assign om_fz   = ONE - fz_q;
	assign w_fx    = {{(BW_M-WW){1'b0}}, fx_q};
	assign w_fz    = {{(BW_M-WW){1'b0}}, fz_q};
	assign w_om_fx = {{(BW_M-WW){1'b0}}, om_fx};
	assign w_om_fz = {{(BW_M-WW){1'b0}}, om_fz};

	// write index in range
	logic wr_ok;
	assign wr_ok = (px_q < PW'(GRID_VERTS)) && (pz_q < PW'(GRID_VERTS));

	// blend sum divided by one squared, truncated toward zero, clamped
	logic signed [CW-1:0]               sum_bias, sum_sh;
	logic signed [hm_pkg::HEIGHT_W-1:0] res;

	always_comb begin
		sum_bias = acc + (acc[CW-1] ? CW'((64'd1 << SHIFT) - 64'd1) : CW'(0));
		sum_sh   = sum_bias >>> SHIFT;
		if (sum_sh > CW'(hm_pkg::HEIGHT_MAX)) begin
			res = hm_pkg::HEIGHT_W'(hm_pkg::HEIGHT_MAX);
		end else if (sum_sh < CW'(hm_pkg::HEIGHT_MIN)) begin
			res = hm_pkg::HEIGHT_W'(hm_pkg::HEIGHT_MIN);
		end else begin
			res = sum_sh[hm_pkg::HEIGHT_W-1:0];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory access and mac step
	always_comb begin
		state_d        = state_q;
		item_in.ready  = 1'b0;
		load_out       = 1'b0;
		mem_we         = 1'b0;
		mem_addr       = base_q;
		mem_wdata      = hin_q;
		mac_op         = '0;
		case (state_q)
			hm_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
				if (clr_q == ADDR_W'(CELLS - 1)) begin
					state_d = hm_pkg::ST_IDLE;
				end
			end
			hm_pkg::ST_IDLE: begin
				item_in.ready = 1'b1;
				if (item_in.valid) begin
					state_d = (item_in.action == hm_pkg::ACT_SAMPLE) ?
						hm_pkg::ST_SCALE_X : hm_pkg::ST_WR_ADDR;
				end
			end
			hm_pkg::ST_WR_ADDR: begin
				mac_op.en     = 1'b1;
				mac_op.load   = 1'b1;
				mac_op.a      = {{(AW_M-IW){1'b0}}, pz_q[IW-1:0]};
				mac_op.b      = BW_M'(GRID_VERTS);
				mac_op.addend = {{(CW-IW){1'b0}}, px_q[IW-1:0]};
				state_d       = hm_pkg::ST_WR_MEM;
			end
			hm_pkg::ST_WR_MEM: begin
				mem_we   = wr_ok;
				mem_addr = acc[ADDR_W-1:0];
				state_d  = hm_pkg::ST_IDLE;
			end
			hm_pkg::ST_SCALE_X: begin
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.a    = {{(AW_M-PW){1'b0}}, px_q};
				mac_op.b    = {{(BW_M-hm_pkg::RECIP_W){1'b0}}, recip};
				state_d     = hm_pkg::ST_SCALE_Z;
			end
			hm_pkg::ST_SCALE_Z: begin
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.a    = {{(AW_M-PW){1'b0}}, pz_q};
				mac_op.b    = {{(BW_M-hm_pkg::RECIP_W){1'b0}}, recip};
				state_d     = hm_pkg::ST_FIX_Z;
			end
			hm_pkg::ST_FIX_Z: begin
				state_d = hm_pkg::ST_ADDR;
			end
			hm_pkg::ST_ADDR: begin
				mac_op.en     = 1'b1;
				mac_op.load   = 1'b1;
				mac_op.a      = {{(AW_M-IW){1'b0}}, zi_q};
				mac_op.b      = BW_M'(GRID_VERTS);
				mac_op.addend = {{(CW-IW){1'b0}}, xi_q};
				state_d       = hm_pkg::ST_RD0;
			end
			hm_pkg::ST_RD0: begin
				mem_addr = acc[ADDR_W-1:0];
				state_d  = hm_pkg::ST_RD1;
			end
			hm_pkg::ST_RD1: begin
				mem_addr    = base_q + ADDR_W'(1);
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.a    = h_eff;
				mac_op.b    = w_om_fx;
				state_d     = hm_pkg::ST_RD2;
			end
			hm_pkg::ST_RD2: begin
				mem_addr  = base_q + ADDR_W'(GRID_VERTS);
				mac_op.en = 1'b1;
				mac_op.a  = h_eff;
				mac_op.b  = w_fx;
				state_d   = hm_pkg::ST_RD3;
			end
			hm_pkg::ST_RD3: begin
				mem_addr    = base_q + ADDR_W'(GRID_VERTS + 1);
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.a    = h_eff;
				mac_op.b    = w_om_fx;
				state_d     = hm_pkg::ST_RD4;
			end
			hm_pkg::ST_RD4: begin
				mac_op.en = 1'b1;
				mac_op.a  = h_eff;
				mac_op.b  = w_fx;
				state_d   = hm_pkg::ST_BL0;
			end
			hm_pkg::ST_BL0: begin
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.a    = acc[AW_M-1:0];
				mac_op.b    = w_fz;
				state_d     = hm_pkg::ST_BL1;
			end
			hm_pkg::ST_BL1: begin
				mac_op.en = 1'b1;
				mac_op.a  = row_a_q;
				mac_op.b  = w_om_fz;
				state_d   = hm_pkg::ST_DONE;
			end
			hm_pkg::ST_DONE: begin
				if (!out_valid_q || result_out.ready) begin
					load_out = 1'b1;
					state_d  = hm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hm_pkg::ST_IDLE;
			end
		endcase
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == hm_pkg::ST_CLEAR) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// item capture and per-sample working registers
	always_ff @(posedge clk) begin
		if (state_q == hm_pkg::ST_IDLE && item_in.valid) begin
			px_q  <= item_in.pos_x;
			pz_q  <= item_in.pos_z;
			hin_q <= item_in.height_in;
		end
		if (state_q == hm_pkg::ST_SCALE_Z) begin
			xi_q   <= ci_adj;
			fx_q   <= cf_adj;
			x_ok_q <= c_in_grid;
		end
		if (state_q == hm_pkg::ST_FIX_Z) begin
			zi_q   <= ci_adj;
			fz_q   <= cf_adj;
			z_ok_q <= c_in_grid;
		end
		if (state_q == hm_pkg::ST_RD0) begin
			base_q <= acc[ADDR_W-1:0];
		end
		if (state_q == hm_pkg::ST_RD3) begin
			row_a_q <= acc[AW_M-1:0];
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			height_q <= res;
		end
	end

	assign result_out.valid      = out_valid_q;
	assign result_out.height_out = height_q;

endmodule

`default_nettype wire

### sv/hm_checker.sv
// hm_checker: port-level assertions on the heightmap sampler, bound to the top
// depends on hm_pkg and heightmap_bilinear_sampler
`timescale 1ns / 1ps
`default_nettype none

module hm_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [hm_pkg::HEIGHT_W-1:0] height_out
);

	// one item at a time: no item is taken right after an accepted one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted in the cycle after an accepted item");

	// a result appears only at the end of a busy stretch
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while input side was idle");

	// reset starts the clearing pass, so no item is taken just after it
	a_clear_after_reset: assert property (@(posedge clk)
		!arst_n |=> !in_ready)
		else $error("item ready during the clearing pass");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(height_out)))
		else $error("stalled result changed or dropped");

endmodule

bind heightmap_bilinear_sampler hm_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item_in.valid),
	.in_ready   (item_in.ready),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.height_out (result_out.height_out)
);

`default_nettype wire

### tb/heightmap_bilinear_sampler_tb.sv
// heightmap_bilinear_sampler_tb: self-checking bench for the heightmap sampler
// drives write and sample items plus apb register writes and reads, checks every height
// depends on hm_pkg, hm_if and heightmap_bilinear_sampler
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_tb;

	import hm_pkg::*;

	localparam int      GV          = GRID_VERTS_DEF;
	localparam int      FRAC        = FRAC_BITS_DEF;
	localparam longint  FRAC_ONE    = longint'(1) << FRAC;
	localparam int      WIN         = 8;
	localparam int      SETTLE      = 20;
	localparam int      CYCLE_LIMIT = 400000;
	localparam int      PHASES      = 9;
	localparam int      PHASE_ITEMS = 80;
	localparam int      DIR_ROWS    = 22;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 1'b1;

	typedef struct packed {
		logic                       action;
		logic [POS_W-1:0]           pos_x;
		logic [POS_W-1:0]           pos_z;
		logic signed [HEIGHT_W-1:0] height;
	} hm_item_t;

	typedef struct packed {
		hm_item_t                   item;
		logic                       known;
		logic signed [HEIGHT_W-1:0] result;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	hm_item_if   item_bus ();
	hm_result_if result_bus ();

	heightmap_bilinear_sampler u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.item_in    (item_bus),
		.result_out (result_bus)
	);

	// shadow of the block state
	logic signed [HEIGHT_W-1:0] height_grid [GV][GV];
	logic [RECIP_W-1:0]         cell_recip;
	logic signed [HEIGHT_W-1:0] pending_heights [$];

	int unsigned fail_count;
	int unsigned cycle_count;
	int          idle_pct;
	int          stall_pct;
	int          win_col;
	int          win_row;

	// directed items, reciprocal at its reset value so world q16.8 equals grid q.8
	dir_row_t dir_table [DIR_ROWS] = '{
		'{'{ACT_SAMPLE, 24'h000000, 24'h000000, 16'sh0000}, 1'b1, 16'sh0000},
		'{'{ACT_SAMPLE, 24'hFFFFFF, 24'hFFFFFF, 16'sh0000}, 1'b1, 16'sh0000},
		'{'{ACT_WRITE,  24'd0,      24'd0,      16'sh7FFF}, 1'b0, 16'sh0000},
		'{'{ACT_WRITE,  24'd1,      24'd0,      16'sh8000}, 1'b0, 16'sh0000},
		'{'{ACT_WRITE,  24'd0,      24'd1,      16'sh5555}, 1'b0, 16'sh0000},
		'{'{ACT_WRITE,  24'd1,      24'd1,      16'shAAAA}, 1'b0, 16'sh0000},
		'{'{ACT_SAMPLE, 24'h000000, 24'h000000, 16'sh0000}, 1'b1, 16'sh7FFF},
		'{'{ACT_SAMPLE, 24'h000080, 24'h000080, 16'sh0000}, 1'b0, 16'sh0000},
		'{'{ACT_SAMPLE, 24'h000040, 24'h0000C0, 16'sh0000}, 1'b0, 16'sh0000},
		'{'{ACT_WRITE,  24'd65,     24'd0,      16'sh04D2}, 1'b0, 16'sh0000},
		'{'{ACT_WRITE,  24'd0,      24'd65,     16'sh04D2}, 1'b0, 16'sh0000},
		'{'{ACT_WRITE,  24'hFFFFFF, 24'hFFFFFF, 16'shFFFF}, 1'b0, 16'sh0000},
		'{'{ACT_SAMPLE, 24'h000000, 24'h000000, 16'sh0000}, 1'b1, 16'sh7FFF},
		'{'{ACT_WRITE,  24'd64,     24'd64,     16'sh8000}, 1'b0, 16'sh0000},
		'{'{ACT_WRITE,  24'd63,     24'd64,     16'sh7FFF}, 1'b0, 16'sh0000},
		'{'{ACT_WRITE,  24'd64,     24'd63,     16'sh3039}, 1'b0, 16'sh0000},
		'{'{ACT_SAMPLE, 24'h004000, 24'h004000, 16'sh0000}, 1'b1, 16'sh8000},
		'{'{ACT_SAMPLE, 24'h004080, 24'h004000, 16'sh0000}, 1'b0, 16'sh0000},
		'{'{ACT_SAMPLE, 24'h003FC0, 24'h004000, 16'sh0000}, 1'b0, 16'sh0000},
		'{'{ACT_SAMPLE, 24'h004100, 24'h000000, 16'sh0000}, 1'b1, 16'sh0000},
		'{'{ACT_SAMPLE, 24'h0040FF, 24'h003F40, 16'sh0000}, 1'b0, 16'sh0000},
		'{'{ACT_SAMPLE, 24'h003F80, 24'h003F80, 16'sh0000}, 1'b0, 16'sh0000}
	};

	// reciprocal per phase; the slot at index 6 is replaced by a random value
	logic [RECIP_W-1:0] phase_recip [PHASES] = '{
		24'h010000, 24'hFFFFFF, 24'h000001, 24'h000000, 24'h020000,
		24'h001000, 24'h010000, 24'h00C000, 24'h010000
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// height of one vertex, zero off the grid
	function automatic longint vertex_height(input longint col, input longint row);
		if (col >= GV || row >= GV)
			return 0;
		return height_grid[row][col];
	endfunction

	// bilinear blend of the four neighbors of a world position
	function automatic logic signed [HEIGHT_W-1:0] blend_height(
		input logic [POS_W-1:0] wx,
		input logic [POS_W-1:0] wz
	);
		longint gx, gz, xi, zi, fx, fz, acc;
		gx = longint'(({24'b0, wx} * {24'b0, cell_recip}) >> (PROD_FRAC - FRAC));
		gz = longint'(({24'b0, wz} * {24'b0, cell_recip}) >> (PROD_FRAC - FRAC));
		xi = gx >> FRAC;
		zi = gz >> FRAC;
		fx = gx & (FRAC_ONE - 1);
		fz = gz & (FRAC_ONE - 1);
		// last column or row steps back one cell with a full fraction
		if (xi == GV - 1) begin
			xi = xi - 1;
			fx = FRAC_ONE;
		end
		if (zi == GV - 1) begin
			zi = zi - 1;
			fz = FRAC_ONE;
		end
		acc = (FRAC_ONE - fx) * (FRAC_ONE - fz) * vertex_height(xi, zi)
			+ (FRAC_ONE - fx) * fz * vertex_height(xi, zi + 1)
			+ fx * (FRAC_ONE - fz) * vertex_height(xi + 1, zi)
			+ fx * fz * vertex_height(xi + 1, zi + 1);
		// signed division truncates toward zero
		acc = acc / (FRAC_ONE * FRAC_ONE);
		return acc[HEIGHT_W-1:0];
	endfunction

	// update the shadow grid or work out the sampled height
	function automatic bit predict_item(
		input  hm_item_t                   it,
		output logic signed [HEIGHT_W-1:0] h
	);
		h = '0;
		if (it.action == ACT_WRITE) begin
			if (it.pos_x < GV && it.pos_z < GV)
				height_grid[it.pos_z][it.pos_x] = it.height;
			return 1'b0;
		end
		h = blend_height(it.pos_x, it.pos_z);
		return 1'b1;
	endfunction

	// world coordinate that lands on a given grid q.8 position
	function automatic logic [POS_W-1:0] world_of(input longint g);
		longint w;
		if (cell_recip == 0)
			return POS_W'($urandom);
		w = (g << (PROD_FRAC - FRAC)) / longint'(cell_recip);
		if (w > longint'(24'hFFFFFF))
			w = longint'(24'hFFFFFF);
		return POS_W'(w);
	endfunction

	// random item: mostly writes and samples inside a small window, some noise
	function automatic hm_item_t random_item();
		hm_item_t    it;
		int unsigned pick;
		longint      gq_x, gq_z;
		pick      = $urandom_range(0, 99);
		it.height = HEIGHT_W'($urandom);
		if (pick < 30) begin
			it.action = ACT_WRITE;
			it.pos_x  = POS_W'(win_col + $urandom_range(0, WIN - 1));
			it.pos_z  = POS_W'(win_row + $urandom_range(0, WIN - 1));
		end else if (pick < 85) begin
			it.action = ACT_SAMPLE;
			gq_x = (longint'(win_col + $urandom_range(0, WIN - 1)) << FRAC)
				+ $urandom_range(0, FRAC_ONE - 1);
			gq_z = (longint'(win_row + $urandom_range(0, WIN - 1)) << FRAC)
				+ $urandom_range(0, FRAC_ONE - 1);
			it.pos_x = world_of(gq_x);
			it.pos_z = world_of(gq_z);
		end else begin
			it.action = 1'($urandom);
			it.pos_x  = POS_W'($urandom);
			it.pos_z  = POS_W'($urandom);
		end
		return it;
	endfunction

	// offer one item with random gaps, predict it once accepted
	task automatic drive_item(
		input hm_item_t                   it,
		input logic                       known,
		input logic signed [HEIGHT_W-1:0] typed
	);
		logic signed [HEIGHT_W-1:0] h;
		while ($urandom_range(0, 99) < idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid     <= 1'b1;
		item_bus.action    <= it.action;
		item_bus.pos_x     <= it.pos_x;
		item_bus.pos_z     <= it.pos_z;
		item_bus.height_in <= it.height;
		do @(posedge clk); while (!item_bus.ready);
		if (predict_item(it, h))
			pending_heights = {pending_heights, (known ? typed : h)};
	endtask

	// stop sending until every pending height is back
	task automatic wait_drain(input bit settle);
		item_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_heights.size() != 0);
		if (settle)
			repeat (SETTLE) @(posedge clk);
	endtask

	// apb write: setup then access
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx) << 2;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_CELL_RECIP)
			cell_recip = data[RECIP_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// apb read of the reciprocal, checked against the shadow copy
	task automatic recip_read_check();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'(REG_CELL_RECIP) << 2;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(cell_recip)) begin
			$error("cell_reciprocal mismatch: expected %0d, got %0d", cell_recip, prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// result side back-pressure
	always @(posedge clk)
		result_bus.ready <= ($urandom_range(0, 99) >= stall_pct);

	// compare each returned height with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_heights.size() == 0) begin
				$error("height_out: unexpected item, got %0d", result_bus.height_out);
				fail_count++;
			end else begin
				if (result_bus.height_out !== pending_heights[0]) begin
					$error("height_out mismatch: expected %0d, got %0d",
						pending_heights[0], result_bus.height_out);
					fail_count++;
				end
				void'(pending_heights.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// main sequence
	initial begin
		hm_item_t it;
		fail_count  = 0;
		cycle_count = 0;
		idle_pct    = 0;
		stall_pct   = 0;
		win_col     = 0;
		win_row     = 0;
		cell_recip  = RECIP_RESET;
		foreach (height_grid[r, c])
			height_grid[r][c] = '0;
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		item_bus.valid     <= 1'b0;
		item_bus.action    <= ACT_WRITE;
		item_bus.pos_x     <= '0;
		item_bus.pos_z     <= '0;
		item_bus.height_in <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the register
		recip_read_check();

		// directed table
		foreach (dir_table[i])
			drive_item(dir_table[i].item, dir_table[i].known, dir_table[i].result);
		wait_drain(1'b1);

		// random phases, each with its own reciprocal, window and idling mode
		for (int p = 0; p < PHASES; p++) begin
			if (p == 6)
				phase_recip[p] = RECIP_W'($urandom_range(1, 24'hFFFFFF));
			// unknown register index must leave the reciprocal alone
			if (p == 3)
				reg_write(REG_UNUSED, PDATA_W'($urandom));
			reg_write(REG_CELL_RECIP, PDATA_W'(phase_recip[p]));
			recip_read_check();
			// even phases work the far corner, odd ones a random window
			win_col = (p % 2 == 0) ? GV - WIN : $urandom_range(0, GV - WIN);
			win_row = (p % 2 == 0) ? GV - WIN : $urandom_range(0, GV - WIN);
			case (p % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 69;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 69;
				end
				default: begin
					idle_pct  = 29;
					stall_pct = 29;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold off mid-phase until the block has handed back everything
				if (p == 2 && n == PHASE_ITEMS / 2)
					wait_drain(1'b0);
				it = random_item();
				drive_item(it, 1'b0, '0);
			end
			wait_drain(1'b1);
		end

		if (pending_heights.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
